[rtl/brb_pkg.sv]
package brb_pkg;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_FLUSH   = 2'd2;
    localparam logic [1:0] REQ_DISCARD = 2'd3;

    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_NORMAL = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int LEN_W = 13;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_byte;
        logic       last_of_burst;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       done_res;
        logic       refused;
        logic [1:0] fill_status;
    } result_t;

endpackage

[rtl/brb_ram.sv]
module brb_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/brb_ctrl.sv]
module brb_ctrl #(
    parameter int DEPTH = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_accept,
    input  brb_pkg::item_t               item,
    input  logic                         cfg_accept,
    input  logic [brb_pkg::LEN_W-1:0]    cfg_length,
    output logic                         res_valid,
    output brb_pkg::result_t             res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] last_end_reg, last_end_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] len_reg, len_next;
    logic          lock_reg, lock_next;
    logic          in_burst_reg, in_burst_next;
    logic [1:0]    status_reg, status_next;

    logic          res_valid_reg;
    logic          res_use_ram_reg, res_use_ram_next;
    logic          res_done_reg, res_done_next;
    logic          res_refused_reg, res_refused_next;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic          cfg_ok;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [CW-1:0] len);
        logic [CW-1:0] nxt;
        nxt = CW'(p) + CW'(1);
        return (nxt >= len) ? '0 : nxt[PW-1:0];
    endfunction

    assign cfg_ok = (cfg_length != '0) && (32'(cfg_length) <= 32'(DEPTH));

    always_comb begin
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        last_end_next    = last_end_reg;
        fill_next        = fill_reg;
        len_next         = len_reg;
        lock_next        = lock_reg;
        in_burst_next    = in_burst_reg;
        status_next      = status_reg;
        res_use_ram_next = 1'b0;
        res_done_next    = 1'b0;
        res_refused_next = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (cfg_accept && cfg_ok) begin
            len_next    = CW'(cfg_length);
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
            status_next = brb_pkg::ST_EMPTY;
        end

        if (item_accept) begin
            unique case (item.req_type)
                brb_pkg::REQ_WRITE: begin
                    if (lock_reg) begin
                        res_refused_next = 1'b1;
                    end else if (fill_reg < len_reg) begin
                        ram_we        = 1'b1;
                        wr_ptr_next   = advance(wr_ptr_reg, len_reg);
                        fill_next     = fill_reg + CW'(1);
                        status_next   = (fill_next == len_reg) ? brb_pkg::ST_FULL
                                                               : brb_pkg::ST_NORMAL;
                        res_done_next = 1'b1;
                    end
                end
                brb_pkg::REQ_READ: begin
                    if (fill_reg != '0) begin
                        if (!in_burst_reg && last_end_reg == '0) begin
                            lock_next = 1'b0;
                        end
                        ram_re           = 1'b1;
                        rd_ptr_next      = advance(rd_ptr_reg, len_reg);
                        fill_next        = fill_reg - CW'(1);
                        status_next      = (fill_reg == CW'(1)) ? brb_pkg::ST_EMPTY
                                                                : brb_pkg::ST_NORMAL;
                        last_end_next    = rd_ptr_next;
                        res_use_ram_next = 1'b1;
                        res_done_next    = 1'b1;
                    end
                    in_burst_next = !item.last_of_burst;
                end
                brb_pkg::REQ_FLUSH: begin
                    lock_next = 1'b1;
                end
                brb_pkg::REQ_DISCARD: begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    fill_next   = '0;
                    status_next = brb_pkg::ST_EMPTY;
                    lock_next   = 1'b0;
                end
                default: begin
                    lock_next = lock_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            last_end_reg  <= '0;
            fill_reg      <= '0;
            len_reg       <= CW'(DEPTH);
            lock_reg      <= 1'b0;
            in_burst_reg  <= 1'b0;
            status_reg    <= brb_pkg::ST_EMPTY;
            res_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            last_end_reg  <= last_end_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            lock_reg      <= lock_next;
            in_burst_reg  <= in_burst_next;
            status_reg    <= status_next;
            res_valid_reg <= item_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            res_use_ram_reg <= res_use_ram_next;
            res_done_reg    <= res_done_next;
            res_refused_reg <= res_refused_next;
        end
    end

    brb_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (item.write_byte),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign res_valid       = res_valid_reg;
    assign res.read_byte   = res_use_ram_reg ? ram_rdata : 8'd0;
    assign res.done_res    = res_done_reg;
    assign res.refused     = res_refused_reg;
    assign res.fill_status = status_reg;

endmodule

[rtl/brb_outq.sv]
module brb_outq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  brb_pkg::result_t push_data,
    input  logic             pop,
    output logic             head_valid,
    output brb_pkg::result_t head_data,
    output logic [1:0]       count
);

    brb_pkg::result_t entry_reg [2];
    logic             head_reg, head_next;
    logic             tail_reg, tail_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = push ? ~tail_reg : tail_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[head_reg];
    assign count      = count_reg;

endmodule

[rtl/byte_ring_buffer_stream_core.sv]
// Byte ring buffer with a flush lock, one byte per item.
// Input channel s_*: req_type selects write, read, flush lock or discard;
// write_byte is stored on a write; last_of_burst marks the final byte of a
// software call. Output channel m_*: exactly one result item per input
// item, in order: read_byte, done_res, refused and the fill status after
// the item. Configuration channel cfg_*: writes the usable ring length
// (1..DEPTH, other values are dropped) and empties the queue.
// The result passes through the controller's result register and then the
// result queue before m_valid rises.
// Throughput: one item per cycle for any request mix while results are
// taken; the byte memory is read in the cycle of acceptance and its
// registered output feeds the result in the next cycle, so reads and writes never collide.
// The two-entry result queue lets the block keep accepting items while a
// result waits; when m_ready stays low the queue fills and s_ready drops,
// nothing is lost.
// Reset (aresetn low, synchronous) empties the queue, clears the lock and
// burst tracking and sets the length to DEPTH. No clearing pass is needed:
// the byte memory is only read where it was written.
module byte_ring_buffer_stream_core #(
    parameter int DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [7:0]                    s_write_byte,
    input  logic                          s_last_of_burst,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_read_byte,
    output logic                          m_done_res,
    output logic                          m_refused,
    output logic [1:0]                    m_fill_status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brb_pkg::LEN_W-1:0]     cfg_buffer_length
);

    brb_pkg::item_t   item;
    brb_pkg::result_t res;
    brb_pkg::result_t head;
    logic             res_valid;
    logic             item_accept;
    logic             pop;
    logic [1:0]       q_count;
    logic [1:0]       occupied;

    assign item.req_type      = s_req_type;
    assign item.write_byte    = s_write_byte;
    assign item.last_of_burst = s_last_of_burst;

    assign pop         = m_valid && m_ready;
    assign occupied    = q_count + {1'b0, res_valid};
    assign s_ready     = pop ? (occupied <= 2'd2) : (occupied <= 2'd1);
    assign item_accept = s_valid && s_ready;
    assign cfg_ready   = 1'b1;

    brb_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .item        (item),
        .cfg_accept  (cfg_valid),
        .cfg_length  (cfg_buffer_length),
        .res_valid   (res_valid),
        .res         (res)
    );

    brb_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .head_valid (m_valid),
        .head_data  (head),
        .count      (q_count)
    );

    assign m_read_byte   = head.read_byte;
    assign m_done_res    = head.done_res;
    assign m_refused     = head.refused;
    assign m_fill_status = head.fill_status;

endmodule

[tb/ring_buffer_checker.sv]
module ring_buffer_checker #(
    parameter int DEPTH = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_req_type,
    input  logic [7:0]                s_write_byte,
    input  logic                      s_last_of_burst,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [7:0]                m_read_byte,
    input  logic                      m_done_res,
    input  logic                      m_refused,
    input  logic [1:0]                m_fill_status,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [brb_pkg::LEN_W-1:0] cfg_buffer_length,
    output int                        errors,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LEN_W = brb_pkg::LEN_W;

    logic [7:0]       ring_mem [DEPTH];
    logic [LEN_W-1:0] ring_len;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [LEN_W-1:0] fill;
    logic             lock;
    logic [PTR_W-1:0] read_end;
    logic             in_read_burst;
    logic [1:0]       status;

    brb_pkg::result_t due_results [$];

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [LEN_W-1:0] n;
        n = LEN_W'(p) + 1'b1;
        return (n >= ring_len) ? '0 : n[PTR_W-1:0];
    endfunction

    task automatic empty_ring();
        fill = '0;
        rd_ptr = '0;
        wr_ptr = '0;
        status = brb_pkg::ST_EMPTY;
    endtask

    task automatic take_length(input logic [LEN_W-1:0] v);
        if (v != 0 && v <= DEPTH) begin
            ring_len = v;
            empty_ring();
        end
    endtask

    task automatic apply_request(input brb_pkg::item_t it, output brb_pkg::result_t res);
        logic opens;
        res = '0;
        case (it.req_type)
            brb_pkg::REQ_WRITE: begin
                if (lock) begin
                    res.refused = 1'b1;
                end else if (fill < ring_len) begin
                    if (wr_ptr >= ring_len) wr_ptr = '0;
                    ring_mem[wr_ptr] = it.write_byte;
                    wr_ptr = next_slot(wr_ptr);
                    fill = fill + 1'b1;
                    status = (fill == ring_len) ? brb_pkg::ST_FULL : brb_pkg::ST_NORMAL;
                    res.done_res = 1'b1;
                end
            end
            brb_pkg::REQ_READ: begin
                opens = !in_read_burst;
                if (fill > 0) begin
                    if (opens && read_end == 0) lock = 1'b0;
                    if (rd_ptr >= ring_len) rd_ptr = '0;
                    res.read_byte = ring_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                    fill = fill - 1'b1;
                    status = (fill == 0) ? brb_pkg::ST_EMPTY : brb_pkg::ST_NORMAL;
                    read_end = rd_ptr;
                    res.done_res = 1'b1;
                end
                in_read_burst = !it.last_of_burst;
            end
            brb_pkg::REQ_FLUSH: begin
                lock = 1'b1;
            end
            default: begin
                empty_ring();
                lock = 1'b0;
            end
        endcase
        res.fill_status = status;
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        brb_pkg::item_t   it;
        brb_pkg::result_t want;
        if (!aresetn) begin
            ring_len = LEN_W'(DEPTH);
            empty_ring();
            lock = 1'b0;
            read_end = '0;
            in_read_burst = 1'b0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no item pending, expected none got %0h/%0b/%0b/%0d",
                             $time, m_read_byte, m_done_res, m_refused, m_fill_status);
                end else begin
                    want = due_results.pop_front();
                    flag_field("read_byte", want.read_byte, m_read_byte);
                    flag_field("done_res", want.done_res, m_done_res);
                    flag_field("refused", want.refused, m_refused);
                    flag_field("fill_status", want.fill_status, m_fill_status);
                end
            end
            if (cfg_valid && cfg_ready) take_length(cfg_buffer_length);
            if (s_valid && s_ready) begin
                it.req_type = s_req_type;
                it.write_byte = s_write_byte;
                it.last_of_burst = s_last_of_burst;
                apply_request(it, want);
                due_results.push_back(want);
            end
        end
        pending = due_results.size();
    end

endmodule

[tb/byte_ring_buffer_stream_core_tb.sv]
module byte_ring_buffer_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 4096;
    localparam int LEN_W = brb_pkg::LEN_W;
    localparam int CYCLE_LIMIT = 600000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_req_type;
    logic [7:0]       s_write_byte;
    logic             s_last_of_burst;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_read_byte;
    logic             m_done_res;
    logic             m_refused;
    logic [1:0]       m_fill_status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_buffer_length;

    int fail_count;
    int in_flight;
    int cycles = 0;
    int sent = 0;

    byte_ring_buffer_stream_core #(.DEPTH(DEPTH)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_write_byte      (s_write_byte),
        .s_last_of_burst   (s_last_of_burst),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_byte       (m_read_byte),
        .m_done_res        (m_done_res),
        .m_refused         (m_refused),
        .m_fill_status     (m_fill_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_buffer_length (cfg_buffer_length)
    );

    ring_buffer_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_write_byte      (s_write_byte),
        .s_last_of_burst   (s_last_of_burst),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_byte       (m_read_byte),
        .m_done_res        (m_done_res),
        .m_refused         (m_refused),
        .m_fill_status     (m_fill_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_buffer_length (cfg_buffer_length),
        .errors            (fail_count),
        .pending           (in_flight)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stall the result side per item
    initial begin : drain
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [7:0] data, input logic last);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type = req;
        s_write_byte = data;
        s_last_of_burst = last;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic send_burst(input logic [1:0] req, input int n);
        for (int i = 0; i < n; i++)
            send_item(req, 8'($urandom_range(0, 255)), i == n - 1);
    endtask

    // hold items back until every result is in, then write the length
    task automatic write_length(input logic [LEN_W-1:0] v);
        s_valid = 1'b0;
        while (in_flight != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_buffer_length = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return LEN_W'(1);
            1: return LEN_W'(2);
            2: return LEN_W'(3);
            3, 4, 5: return LEN_W'($urandom_range(4, 16));
            6, 7: return LEN_W'($urandom_range(17, 300));
            8: return LEN_W'(DEPTH);
            default: return ($urandom_range(0, 1) == 0) ? '0 :
                            LEN_W'($urandom_range(DEPTH + 1, (1 << LEN_W) - 1));
        endcase
    endfunction

    initial begin : stimulus
        int target;
        int r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = brb_pkg::REQ_WRITE;
        s_write_byte = '0;
        s_last_of_burst = 1'b0;
        cfg_valid = 1'b0;
        cfg_buffer_length = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);
        send_item(brb_pkg::REQ_WRITE, 8'h00, 1'b0);
        send_item(brb_pkg::REQ_WRITE, 8'hFF, 1'b1);
        send_item(brb_pkg::REQ_FLUSH, 8'h00, 1'b0);
        send_item(brb_pkg::REQ_WRITE, 8'h12, 1'b1);
        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);
        send_item(brb_pkg::REQ_FLUSH, 8'hFF, 1'b1);
        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);
        send_item(brb_pkg::REQ_WRITE, 8'h34, 1'b1);
        send_item(brb_pkg::REQ_DISCARD, 8'h00, 1'b0);
        send_item(brb_pkg::REQ_WRITE, 8'hAA, 1'b0);
        send_item(brb_pkg::REQ_WRITE, 8'h55, 1'b1);
        send_burst(brb_pkg::REQ_READ, 3);
        write_length(LEN_W'(1));
        send_item(brb_pkg::REQ_WRITE, 8'h01, 1'b1);
        send_item(brb_pkg::REQ_WRITE, 8'h02, 1'b1);
        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);
        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);
        write_length('0);
        write_length('1);
        write_length(LEN_W'(DEPTH + 1));
        send_item(brb_pkg::REQ_WRITE, 8'h5A, 1'b1);
        send_item(brb_pkg::REQ_WRITE, 8'hA5, 1'b1);
        send_item(brb_pkg::REQ_READ, 8'h00, 1'b1);

        // small ring: fill, overflow, wrap, drop
        write_length(LEN_W'(64));
        repeat (64)
            send_item(brb_pkg::REQ_WRITE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        send_item(brb_pkg::REQ_WRITE, 8'h77, 1'b1);
        send_burst(brb_pkg::REQ_READ, 5);
        send_burst(brb_pkg::REQ_WRITE, 6);
        send_burst(brb_pkg::REQ_READ, 4);
        send_item(brb_pkg::REQ_DISCARD, 8'h00, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            write_length(pick_length());
            target = sent + 75;
            while (sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    send_burst(brb_pkg::REQ_WRITE, $urandom_range(1, 8));
                else if (r < 78)
                    send_burst(brb_pkg::REQ_READ, $urandom_range(1, 8));
                else if (r < 85)
                    send_item(brb_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else if (r < 89)
                    send_item(brb_pkg::REQ_DISCARD, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                else
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
            end
        end

        s_valid = 1'b0;
        while (in_flight != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
